### rtl/rspu_pkg.sv
`timescale 1ns / 1ps
package rspu_pkg;

  // operation codes
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  // register map, bit 0 of the offset cleared
  localparam logic [11:0] OffChipId    = 12'h000;
  localparam logic [11:0] OffIrqFlags  = 12'h010;
  localparam logic [11:0] OffIrqEnable = 12'h012;
  localparam logic [11:0] OffRandom    = 12'h044;
  localparam logic [11:0] OffBbHeader  = 12'h158;
  localparam logic [11:0] OffBbWrite   = 12'h15a;
  localparam logic [11:0] OffBbRead    = 12'h15c;
  localparam logic [11:0] OffBbBusy    = 12'h15e;
  localparam logic [11:0] OffRfHigh    = 12'h17c;
  localparam logic [11:0] OffRfLow     = 12'h17e;
  localparam logic [11:0] OffRfBusy    = 12'h180;
  localparam logic [11:0] OffIrqSet    = 12'h21c;

  localparam logic [15:0] ChipId     = 16'hc340;
  localparam logic [15:0] IrqSetSkip = 16'h0400;

  localparam int RfRegCount = 32;
  localparam int RfAddrW    = 5;
  localparam int RfRegW     = 18;

  typedef struct packed {
    logic capture;  // take the input word, issue the store read
    logic exec;     // carry out the held item
  } cmd_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] off;
    logic [15:0] wdata;
  } item_t;

  // power-on contents of the baseband store
  function automatic logic [7:0] bb_reset_val(input logic [7:0] a);
    logic [7:0] v;
    case (a)
      8'h00:   v = 8'h6d;
      8'h4d:   v = 8'hff;
      8'h5d:   v = 8'h01;
      8'h64:   v = 8'hff;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic bb_fixed_protected(input logic [7:0] a);
    return a inside {[8'h0d:8'h12], [8'h16:8'h1a], [8'h5d:8'h61],
                     8'h00, 8'h27, 8'h4d, 8'h64, 8'h66};
  endfunction

  // power-on contents of the RF register file
  function automatic logic [RfRegW-1:0] rf_por(input logic [RfAddrW-1:0] a);
    logic [RfRegW-1:0] v;
    case (a)
      5'h00:   v = 18'h00007;
      5'h01:   v = 18'h09003;
      5'h02:   v = 18'h00022;
      5'h03:   v = 18'h1ff78;
      5'h04:   v = 18'h09003;
      5'h05:   v = 18'h01780;
      5'h07:   v = 18'h14578;
      5'h08:   v = 18'h1e742;
      5'h09:   v = 18'h00120;
      5'h0e:   v = 18'h00022;
      5'h1b:   v = 18'h0000f;
      5'h1f:   v = 18'h00001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/radio_serial_register_ports_unit.sv
`timescale 1ns / 1ps
// Radio serial register ports. Each word on the input channel is a half-word
// bus read (op 0), a half-word write (op 1) or a transfer tick (op 2); each
// gives exactly one result word carrying the read data (zero for writes,
// ticks and unmapped offsets) and the baseband and RF busy bits as they stand
// after the item. A word is taken in the idle state, which also starts the
// registered read of the baseband register memory at the current header address,
// and is carried out in the execute state that follows; no new word is taken
// while an item executes, and a result appears in the cycle after execute.
// A result held by the receiver stalls the input until it is taken.
// The baseband store starts from its power-on contents straight after reset
// through per-entry valid flags, so no clearing pass is needed.
module radio_serial_register_ports_unit #(
  parameter int BB_REG_COUNT   = 105,  // baseband byte registers, 1..256
  parameter int TRANSFER_TICKS = 24    // ticks per serial transfer, 5..31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] addr_i,
  input  logic [15:0] wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        bb_busy_out_o,
  output logic        rf_busy_out_o
);
  import rspu_pkg::*;

  cmd_t        cmd;
  item_t       item_q;
  logic [15:0] bb_rdata, rf_rdata, misc_rdata;
  logic        bb_busy, rf_busy;
  logic [15:0] read_data_q;
  logic        bb_busy_q, rf_busy_q;

  rspu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // held item word; offset bit 0 is dropped here
  always_ff @(posedge clk_i) begin
    if (cmd.capture) begin
      item_q.op    <= op_i;
      item_q.off   <= {addr_i[11:1], 1'b0};
      item_q.wdata <= wdata_i;
    end
  end

  rspu_bb #(
    .BB_REG_COUNT   (BB_REG_COUNT),
    .TRANSFER_TICKS (TRANSFER_TICKS)
  ) u_bb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_q),
    .rdata_o (bb_rdata),
    .busy_o  (bb_busy)
  );

  rspu_rf #(
    .TRANSFER_TICKS (TRANSFER_TICKS)
  ) u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_q),
    .rdata_o (rf_rdata),
    .busy_o  (rf_busy)
  );

  rspu_misc u_misc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_q),
    .rdata_o (misc_rdata)
  );

  // each unit drives zero outside its own offsets, so the read mux is an OR
  always_ff @(posedge clk_i) begin
    if (cmd.exec) begin
      read_data_q <= bb_rdata | rf_rdata | misc_rdata;
      bb_busy_q   <= bb_busy;
      rf_busy_q   <= rf_busy;
    end
  end

  assign read_data_o   = read_data_q;
  assign bb_busy_out_o = bb_busy_q;
  assign rf_busy_out_o = rf_busy_q;

endmodule

### rtl/rspu_ctrl.sv
`timescale 1ns / 1ps
module rspu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rspu_pkg::cmd_t  cmd_o
);
  import rspu_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  // take a word only when the result slot is free by the end of execute
  assign in_stall_o    = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign cmd_o.capture = in_valid_i && !in_stall_o;
  assign cmd_o.exec    = (state_q == StExec);
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (cmd_o.capture) state_d = StExec;
      end
      StExec: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cap_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("captured word not executed");

  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("executed item gave no result");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.exec))
    else $error("result without execute");

endmodule

### rtl/rspu_bb.sv
`timescale 1ns / 1ps
module rspu_bb #(
  parameter int BB_REG_COUNT   = 105,
  parameter int TRANSFER_TICKS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rspu_pkg::cmd_t   cmd_i,
  input  rspu_pkg::item_t  item_i,
  output logic [15:0]      rdata_o,
  output logic             busy_o
);
  import rspu_pkg::*;

  localparam int IW = (BB_REG_COUNT > 1) ? $clog2(BB_REG_COUNT) : 1;
  localparam int TW = $clog2(TRANSFER_TICKS + 1);
  localparam logic [TW-1:0] TicksFull = TW'(TRANSFER_TICKS);
  localparam logic [TW-1:0] BusyAt    = TW'(TRANSFER_TICKS - 4);

  logic [7:0]              mem [BB_REG_COUNT];
  logic [BB_REG_COUNT-1:0] valid_q;
  logic [7:0]              mem_rd_q;
  logic                    mem_rv_q;
  logic                    mem_we;

  logic [15:0]   header_q, header_d;
  logic [7:0]    wbyte_q, wbyte_d;
  logic [7:0]    rbyte_q, rbyte_d;
  logic          busy_q, busy_d;
  logic [TW-1:0] ticks_q, ticks_d;
  logic [TW-1:0] ticks_m1;

  logic [7:0]    addr;
  logic          in_range;
  logic [IW-1:0] idx;
  logic [7:0]    store_val;

  assign addr      = header_q[7:0];
  assign in_range  = {1'b0, addr} < 9'(BB_REG_COUNT);
  assign idx       = addr[IW-1:0];
  // unwritten entries read as their power-on value
  assign store_val = in_range ? (mem_rv_q ? mem_rd_q : bb_reset_val(addr)) : 8'h00;
  assign ticks_m1  = ticks_q - TW'(1);

  always_comb begin
    header_d = header_q;
    wbyte_d  = wbyte_q;
    rbyte_d  = rbyte_q;
    busy_d   = busy_q;
    ticks_d  = ticks_q;
    mem_we   = 1'b0;
    rdata_o  = 16'h0000;
    if (cmd_i.exec) begin
      case (item_i.op)
        OpRead: begin
          case (item_i.off)
            OffBbRead: rdata_o = {8'h00, rbyte_q};
            OffBbBusy: rdata_o = {15'b0, busy_q};
            default:   rdata_o = 16'h0000;
          endcase
        end
        OpWrite: begin
          case (item_i.off)
            OffBbHeader: begin
              header_d = item_i.wdata;
              busy_d   = 1'b0;
              rbyte_d  = 8'h00;
              ticks_d  = TicksFull;
            end
            OffBbWrite: wbyte_d = item_i.wdata[7:0];
            default: ;
          endcase
        end
        OpTick: begin
          if (ticks_q != '0) begin
            ticks_d = ticks_m1;
            if (ticks_m1 != '0) begin
              if (ticks_m1 == BusyAt) busy_d = 1'b1;
            end else begin
              busy_d = 1'b0;
              if (header_q[14]) begin
                if (header_q[13]) rbyte_d = store_val;
                if (header_q[12] && in_range && !bb_fixed_protected(addr)) mem_we = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o = busy_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx] <= wbyte_q;
    if (cmd_i.capture) begin
      mem_rd_q <= mem[idx];
      mem_rv_q <= valid_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      header_q <= '0;
      wbyte_q  <= '0;
      rbyte_q  <= '0;
      busy_q   <= 1'b0;
      ticks_q  <= '0;
    end else begin
      if (mem_we) valid_q[idx] <= 1'b1;
      header_q <= header_d;
      wbyte_q  <= wbyte_d;
      rbyte_q  <= rbyte_d;
      busy_q   <= busy_d;
      ticks_q  <= ticks_d;
    end
  end

endmodule

### rtl/rspu_rf.sv
`timescale 1ns / 1ps
module rspu_rf #(
  parameter int TRANSFER_TICKS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rspu_pkg::cmd_t   cmd_i,
  input  rspu_pkg::item_t  item_i,
  output logic [15:0]      rdata_o,
  output logic             busy_o
);
  import rspu_pkg::*;

  localparam int TW = $clog2(TRANSFER_TICKS + 1);
  localparam logic [TW-1:0] TicksFull = TW'(TRANSFER_TICKS);

  logic [RfRegW-1:0]  regs_q [RfRegCount];
  logic [31:0]        shift_q, shift_d;
  logic               busy_q, busy_d;
  logic [TW-1:0]      ticks_q, ticks_d;
  logic [TW-1:0]      ticks_m1;
  logic [RfAddrW-1:0] ra;
  logic               reg_we;

  assign ra       = shift_q[22:18];
  assign ticks_m1 = ticks_q - TW'(1);

  always_comb begin
    shift_d = shift_q;
    busy_d  = busy_q;
    ticks_d = ticks_q;
    reg_we  = 1'b0;
    rdata_o = 16'h0000;
    if (cmd_i.exec) begin
      case (item_i.op)
        OpRead: begin
          case (item_i.off)
            OffRfHigh: rdata_o = shift_q[31:16];
            OffRfLow:  rdata_o = shift_q[15:0];
            OffRfBusy: rdata_o = {15'b0, busy_q};
            default:   rdata_o = 16'h0000;
          endcase
        end
        OpWrite: begin
          case (item_i.off)
            OffRfHigh: begin
              shift_d = {item_i.wdata, shift_q[15:0]};
              busy_d  = 1'b1;
              ticks_d = TicksFull;
            end
            OffRfLow: shift_d = {shift_q[31:16], item_i.wdata};
            default: ;
          endcase
        end
        OpTick: begin
          if (ticks_q != '0) begin
            ticks_d = ticks_m1;
            if (ticks_m1 == '0) begin
              busy_d = 1'b0;
              // bit 23 picks read-back into the shift word, else write
              if (shift_q[23]) shift_d = {{(32 - RfRegW){1'b0}}, regs_q[ra]};
              else             reg_we  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o = busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RfRegCount; i++) regs_q[i] <= rf_por(RfAddrW'(i));
      shift_q <= '0;
      busy_q  <= 1'b0;
      ticks_q <= '0;
    end else begin
      if (reg_we) regs_q[ra] <= shift_q[RfRegW-1:0];
      shift_q <= shift_d;
      busy_q  <= busy_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

### rtl/rspu_misc.sv
`timescale 1ns / 1ps
module rspu_misc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rspu_pkg::cmd_t   cmd_i,
  input  rspu_pkg::item_t  item_i,
  output logic [15:0]      rdata_o
);
  import rspu_pkg::*;

  logic [10:0] rnd_q, rnd_d;
  logic [15:0] flags_q, flags_d;
  logic [15:0] en_q, en_d;

  always_comb begin
    rnd_d   = rnd_q;
    flags_d = flags_q;
    en_d    = en_q;
    rdata_o = 16'h0000;
    if (cmd_i.exec) begin
      case (item_i.op)
        OpRead: begin
          case (item_i.off)
            OffChipId:    rdata_o = ChipId;
            OffIrqFlags:  rdata_o = flags_q;
            OffIrqEnable: rdata_o = en_q;
            OffRandom: begin
              rdata_o = {5'b0, rnd_q};
              // rotate left, xor old bit 0 back in
              rnd_d   = {rnd_q[9:0], rnd_q[10]} ^ {10'b0, rnd_q[0]};
            end
            default: rdata_o = 16'h0000;
          endcase
        end
        OpWrite: begin
          case (item_i.off)
            OffIrqFlags:  flags_d = flags_q & ~item_i.wdata;
            OffIrqEnable: en_d    = item_i.wdata;
            OffIrqSet:    flags_d = flags_q | (item_i.wdata & ~IrqSetSkip);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= 11'd1;
      flags_q <= '0;
      en_q    <= '0;
    end else begin
      rnd_q   <= rnd_d;
      flags_q <= flags_d;
      en_q    <= en_d;
    end
  end

endmodule

### dv/tb_radio_serial_register_ports_unit.sv
`timescale 1ns / 1ps
module tb_radio_serial_register_ports_unit;
  import rspu_pkg::*;

  localparam int BbRegCount    = 105;
  localparam int TransferTicks = 24;
  localparam int WordTarget    = 1850;
  localparam int IdleLimit     = 500;   // handshake-free cycles before giving up
  localparam int DrainCycles   = 10;    // settle time after the last result

  // op 3 is left undefined by the map: no effect, zero read data
  localparam logic [1:0] OpNone = 2'd3;

  // one result word
  typedef struct packed {
    logic [15:0] rd;
    logic        bb_busy;
    logic        rf_busy;
  } reply_t;

  // one line of the directed table; reps repeats the word, want is used when fixed
  typedef struct {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [15:0] wdata;
    int          reps;
    bit          fixed;
    reply_t      want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [11:0] addr_i;
  logic [15:0] wdata_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] read_data_o;
  logic        bb_busy_out_o;
  logic        rf_busy_out_o;

  // travel with the word so the checker can pick a hand-typed answer
  bit          fixed_q;
  reply_t      want_q;

  radio_serial_register_ports_unit #(
    .BB_REG_COUNT  (BbRegCount),
    .TRANSFER_TICKS(TransferTicks)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .addr_i       (addr_i),
    .wdata_i      (wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .bb_busy_out_o(bb_busy_out_o),
    .rf_busy_out_o(rf_busy_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the register ports
  // ---------------------------------------------------------------------------
  logic [7:0]  bb_mem [0:BbRegCount-1];
  logic [15:0] bb_hdr;
  logic [7:0]  bb_wr_byte;
  logic [7:0]  bb_rd_byte;
  logic        bb_busy;
  logic [4:0]  bb_left;
  logic [17:0] rf_mem [0:31];
  logic [31:0] rf_shift;
  logic        rf_busy;
  logic [4:0]  rf_left;
  logic [10:0] rnd_word;
  logic [15:0] irq_flags;
  logic [15:0] irq_enable;

  task automatic shadow_reset();
    for (int i = 0; i < BbRegCount; i++) bb_mem[i] = 8'h00;
    bb_mem[8'h00] = 8'h6d;
    bb_mem[8'h4d] = 8'hff;
    bb_mem[8'h5d] = 8'h01;
    bb_mem[8'h64] = 8'hff;
    for (int i = 0; i < 32; i++) rf_mem[i] = 18'h0;
    rf_mem[5'h00] = 18'h00007;
    rf_mem[5'h01] = 18'h09003;
    rf_mem[5'h02] = 18'h00022;
    rf_mem[5'h03] = 18'h1ff78;
    rf_mem[5'h04] = 18'h09003;
    rf_mem[5'h05] = 18'h01780;
    rf_mem[5'h07] = 18'h14578;
    rf_mem[5'h08] = 18'h1e742;
    rf_mem[5'h09] = 18'h00120;
    rf_mem[5'h0e] = 18'h00022;
    rf_mem[5'h1b] = 18'h0000f;
    rf_mem[5'h1f] = 18'h00001;
    bb_hdr     = '0;
    bb_wr_byte = '0;
    bb_rd_byte = '0;
    bb_busy    = 1'b0;
    bb_left    = '0;
    rf_shift   = '0;
    rf_busy    = 1'b0;
    rf_left    = '0;
    rnd_word   = 11'd1;
    irq_flags  = '0;
    irq_enable = '0;
  endtask

  // fixed write-protected entries, plus anything past the end of the store
  function automatic bit bb_write_locked(input int a);
    return (a >= 'h0d && a <= 'h12) || (a >= 'h16 && a <= 'h1a) ||
           (a >= 'h5d && a <= 'h61) || a == 'h00 || a == 'h27 ||
           a == 'h4d || a == 'h64 || a == 'h66 || a >= BbRegCount;
  endfunction

  // both ports advance on every tick word
  task automatic shadow_tick();
    int          a;
    logic [4:0]  ra;
    if (bb_left != 0) begin
      bb_left = bb_left - 5'd1;
      if (bb_left != 0) begin
        if (bb_left == TransferTicks - 4) bb_busy = 1'b1;
      end else begin
        bb_busy = 1'b0;
        a = bb_hdr[7:0];
        if (bb_hdr[14]) begin
          if (bb_hdr[13]) bb_rd_byte = (a < BbRegCount) ? bb_mem[a] : 8'h00;
          if (bb_hdr[12] && !bb_write_locked(a)) bb_mem[a] = bb_wr_byte;
        end
      end
    end
    if (rf_left != 0) begin
      rf_left = rf_left - 5'd1;
      if (rf_left == 0) begin
        rf_busy = 1'b0;
        ra = rf_shift[22:18];
        if (rf_shift[23]) rf_shift = {14'h0, rf_mem[ra]};
        else rf_mem[ra] = rf_shift[17:0];
      end
    end
  endtask

  // works out the result word of one accepted word and updates the shadow
  task automatic predict_reply(input logic [1:0] op, input logic [11:0] addr,
                               input logic [15:0] wd, output reply_t r);
    logic [11:0] off;
    logic [10:0] prev;
    off  = {addr[11:1], 1'b0};
    r.rd = 16'h0000;
    if (op == OpRead) begin
      case (off)
        OffChipId:    r.rd = ChipId;
        OffIrqFlags:  r.rd = irq_flags;
        OffIrqEnable: r.rd = irq_enable;
        OffRandom: begin
          prev     = rnd_word;
          r.rd     = {5'h0, prev};
          rnd_word = {prev[9:0], prev[10]} ^ {10'h0, prev[0]};
        end
        OffBbRead:    r.rd = {8'h0, bb_rd_byte};
        OffBbBusy:    r.rd = {15'h0, bb_busy};
        OffRfHigh:    r.rd = rf_shift[31:16];
        OffRfLow:     r.rd = rf_shift[15:0];
        OffRfBusy:    r.rd = {15'h0, rf_busy};
        default:      r.rd = 16'h0000;
      endcase
    end else if (op == OpWrite) begin
      case (off)
        OffIrqFlags:  irq_flags  = irq_flags & ~wd;
        OffIrqEnable: irq_enable = wd;
        OffIrqSet:    irq_flags  = irq_flags | (wd & ~IrqSetSkip);
        OffBbHeader: begin
          bb_hdr     = wd;
          bb_busy    = 1'b0;
          bb_rd_byte = 8'h00;
          bb_left    = 5'(TransferTicks);
        end
        OffBbWrite:   bb_wr_byte = wd[7:0];
        OffRfHigh: begin
          rf_shift[31:16] = wd;
          rf_busy         = 1'b1;
          rf_left         = 5'(TransferTicks);
        end
        OffRfLow:     rf_shift[15:0] = wd;
        default: ;
      endcase
    end else if (op == OpTick) begin
      shadow_tick();
    end
    r.bb_busy = bb_busy;
    r.rf_busy = rf_busy;
  endtask

  // ---------------------------------------------------------------------------
  // Checker: pops the oldest pending word for each result taken, and
  // predicts a new one for each word the block takes in the same edge.
  // ---------------------------------------------------------------------------
  reply_t pending_replies[$];
  reply_t head_reply;
  reply_t new_reply;
  int     mismatches;
  int     idle_cycles;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("unexpected word", read_data_o, 16'h0);
        end else begin
          head_reply = pending_replies.pop_front();
          if (read_data_o !== head_reply.rd)
            flag_mismatch("read_data", read_data_o, head_reply.rd);
          if (bb_busy_out_o !== head_reply.bb_busy)
            flag_mismatch("bb_busy", {15'h0, bb_busy_out_o}, {15'h0, head_reply.bb_busy});
          if (rf_busy_out_o !== head_reply.rf_busy)
            flag_mismatch("rf_busy", {15'h0, rf_busy_out_o}, {15'h0, head_reply.rf_busy});
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_reply(op_i, addr_i, wdata_i, new_reply);
        // hand-typed rows still run the shadow so its state stays in step
        pending_replies.push_back(fixed_q ? want_q : new_reply);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("watchdog: no handshake for %0d cycles", IdleLimit);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls as a repeating 16-bit mask dictates, and the mask is redrawn
  // periodically. A quarter of the masks are drawn empty (no back-pressure at
  // all); every mask keeps at least one open slot so the output always drains.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_mask;
  int          stall_phase;

  initial begin
    out_stall_i = 1'b0;
    stall_mask  = '0;
    stall_phase = 0;
  end

  always @(negedge clk_i) begin
    if (stall_phase % 256 == 0) begin
      if ($urandom_range(0, 3) == 0) stall_mask = '0;
      else stall_mask = 16'($urandom & $urandom);
      stall_mask[$urandom_range(0, 15)] = 1'b0;
    end
    out_stall_i <= stall_mask[stall_phase % 16];
    stall_phase++;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with gaps between them; every so often a
  // stretch of back-to-back words with no gaps at all.
  // ---------------------------------------------------------------------------
  int  words_sent;
  int  burst_left;
  bit  steady;

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic put_word(input logic [1:0] op, input logic [11:0] addr,
                          input logic [15:0] wd, input bit fixed, input reply_t want);
    if (words_sent % 200 == 0) steady = ($urandom_range(0, 3) == 0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady) hold_off($urandom_range(1, 8));
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    addr_i     <= addr;
    wdata_i    <= wd;
    fixed_q    <= fixed;
    want_q     <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic put(input logic [1:0] op, input logic [11:0] addr, input logic [15:0] wd);
    put_word(op, addr, wd, 1'b0, '0);
  endtask

  // a mapped offset, with the ignored low bit set at random
  function automatic logic [11:0] pick_offset();
    logic [11:0] off;
    case ($urandom_range(0, 11))
      0:       off = OffChipId;
      1:       off = OffIrqFlags;
      2:       off = OffIrqEnable;
      3:       off = OffRandom;
      4:       off = OffBbHeader;
      5:       off = OffBbWrite;
      6:       off = OffBbRead;
      7:       off = OffBbBusy;
      8:       off = OffRfHigh;
      9:       off = OffRfLow;
      10:      off = OffRfBusy;
      default: off = OffIrqSet;
    endcase
    return off | 12'($urandom_range(0, 1));
  endfunction

  // one baseband transfer, maybe with an RF transfer alongside, ticked through
  // (or cut short so the next header restarts it), then the results read back
  task automatic transfer_burst();
    logic [15:0] hdr;
    logic [15:0] rf_hi;
    int          ticks;
    put(OpWrite, OffBbWrite, 16'($urandom));
    hdr = 16'($urandom);
    hdr[14] = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) < 7) hdr[7:0] = 8'($urandom_range(0, 'h6f));
    put(OpWrite, OffBbHeader, hdr);
    if ($urandom_range(0, 2) != 0) begin
      put(OpWrite, OffRfLow, 16'($urandom));
      rf_hi = 16'($urandom);
      put(OpWrite, OffRfHigh, rf_hi);
    end
    ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, TransferTicks - 1)
                                        : $urandom_range(TransferTicks, TransferTicks + 3);
    while (ticks > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        put(OpRead, pick_offset(), 16'($urandom));
      end else begin
        put(OpTick, 12'($urandom), 16'($urandom));
        ticks--;
      end
    end
    if ($urandom_range(0, 1) != 0) put(OpRead, OffBbRead, 16'($urandom));
    if ($urandom_range(0, 1) != 0) put(OpRead, OffBbBusy, 16'($urandom));
    if ($urandom_range(0, 1) != 0) put(OpRead, OffRfHigh, 16'($urandom));
    if ($urandom_range(0, 1) != 0) put(OpRead, OffRfLow, 16'($urandom));
    if ($urandom_range(0, 1) != 0) put(OpRead, OffRfBusy, 16'($urandom));
  endtask

  // unstructured words: any op including the unused one, any offset
  task automatic noise_burst();
    logic [11:0] a;
    repeat ($urandom_range(1, 12)) begin
      a = ($urandom_range(0, 1) != 0) ? pick_offset() : 12'($urandom);
      put(2'($urandom_range(0, 3)), a, 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t stim_rows[$];

  task automatic add_row(input logic [1:0] op, input logic [11:0] addr,
                         input logic [15:0] wd, input int reps, input bit fixed,
                         input logic [15:0] rd, input logic bb, input logic rf);
    stim_row_t row;
    row.op      = op;
    row.addr    = addr;
    row.wdata   = wd;
    row.reps    = reps;
    row.fixed   = fixed;
    row.want.rd = rd;
    row.want.bb_busy = bb;
    row.want.rf_busy = rf;
    stim_rows.push_back(row);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OpRead;
    addr_i      = '0;
    wdata_i     = '0;
    fixed_q     = 1'b0;
    want_q      = '0;
    words_sent  = 0;
    burst_left  = 0;
    steady      = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    shadow_reset();

    // chip ID, with and without the ignored low address bit
    add_row(OpRead,  OffChipId,         16'h0000, 1, 1'b1, ChipId,   1'b0, 1'b0);
    add_row(OpRead,  12'h001,           16'hffff, 1, 1'b1, ChipId,   1'b0, 1'b0);
    // random register: 1, then 3 after one advance
    add_row(OpRead,  OffRandom,         16'h0000, 1, 1'b1, 16'h0001, 1'b0, 1'b0);
    add_row(OpRead,  OffRandom | 12'h1, 16'h0000, 1, 1'b1, 16'h0003, 1'b0, 1'b0);
    // flag set port skips bit 10; flag port clears on write-one
    add_row(OpWrite, OffIrqSet,         16'hffff, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffIrqFlags,       16'h0000, 1, 1'b1, 16'hfbff, 1'b0, 1'b0);
    add_row(OpWrite, OffIrqFlags,       16'h0003, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffIrqFlags,       16'h0000, 1, 1'b1, 16'hfbfc, 1'b0, 1'b0);
    add_row(OpWrite, OffIrqEnable,      16'hffff, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffIrqEnable,      16'h0000, 1, 1'b1, 16'hffff, 1'b0, 1'b0);
    // top offset is unmapped; the unused op does nothing
    add_row(OpRead,  12'hfff,           16'hffff, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpNone,  OffChipId,         16'hffff, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    // read-then-write of entry 0x20 alongside an RF read of register 0
    add_row(OpWrite, OffBbWrite,        16'hff5a, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpWrite, OffBbHeader,       16'h7020, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpWrite, OffRfLow,          16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpWrite, OffRfHigh,         16'h0080, 1, 1'b1, 16'h0000, 1'b0, 1'b1);
    add_row(OpTick,  12'h000, 16'h0000, TransferTicks, 1'b0, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffRfHigh,         16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffRfLow,          16'h0000, 1, 1'b1, 16'h0007, 1'b0, 1'b0);
    add_row(OpRead,  OffBbRead,         16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    // read back what the previous transfer wrote
    add_row(OpWrite, OffBbHeader,       16'h6020, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpTick,  12'hfff, 16'hffff, TransferTicks, 1'b0, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffBbRead,         16'h0000, 1, 1'b1, 16'h005a, 1'b0, 1'b0);
    // entry past the store: reads zero, write dropped; RF write to register 0
    add_row(OpWrite, OffBbHeader,       16'h70ff, 1, 1'b1, 16'h0000, 1'b0, 1'b0);
    add_row(OpWrite, OffRfLow,          16'h1234, 1, 1'b0, 16'h0000, 1'b0, 1'b0);
    add_row(OpWrite, OffRfHigh,         16'h0001, 1, 1'b0, 16'h0000, 1'b0, 1'b0);
    add_row(OpTick,  12'h000, 16'h0000, TransferTicks, 1'b0, 16'h0000, 1'b0, 1'b0);
    add_row(OpRead,  OffBbRead,         16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps)
        put_word(stim_rows[i].op, stim_rows[i].addr, stim_rows[i].wdata,
                 stim_rows[i].fixed, stim_rows[i].want);
    end

    // mostly well-formed transfers, the rest noise
    while (words_sent < WordTarget) begin
      if ($urandom_range(0, 9) < 7) transfer_burst();
      else noise_burst();
    end

    hold_off(1);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### radio_serial_register_ports_unit.f
rtl/rspu_pkg.sv
rtl/rspu_ctrl.sv
rtl/rspu_bb.sv
rtl/rspu_rf.sv
rtl/rspu_misc.sv
rtl/radio_serial_register_ports_unit.sv
dv/tb_radio_serial_register_ports_unit.sv
